// ===== sv/wildcard_star_regex_matcher_core_macros.svh =====
// Assertion macros shared by the checker of the wildcard star regex matcher.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef WILDCARD_STAR_REGEX_MATCHER_CORE_MACROS_SVH
`define WILDCARD_STAR_REGEX_MATCHER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSRM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WSRM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/wsrm_pkg.sv =====
// Package of the wildcard star regex matcher: constants, register indexes and
// the item and result types. Depends on nothing.
package wsrm_pkg;

    localparam int PATTERN_MAX_DEF = 16;

    localparam logic [7:0] STAR_BYTE = 8'h2A;
    localparam logic [7:0] DOT_BYTE  = 8'h2E;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int LEN_REG_W  = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LOW  = 2'd0,
        CFG_PAT_HIGH = 2'd1,
        CFG_PAT_LEN  = 2'd2
    } cfg_idx_t;

    // Request kinds carried in the input tuser.
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_BYTE  = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] text_byte;
    } wsrm_item_t;

    typedef struct packed {
        logic bad_pattern;
        logic whole_match;
    } wsrm_result_t;

endpackage

// ===== sv/wsrm_cfg_regs.sv =====
// Pattern configuration registers of the wildcard star regex matcher.
// Holds the pattern bytes and length; derives the length in use and the
// leading-star flag. Depends on wsrm_pkg.
module wsrm_cfg_regs #(
    parameter int PATTERN_MAX = wsrm_pkg::PATTERN_MAX_DEF,
    parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [wsrm_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  logic [wsrm_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    output logic [PATTERN_MAX-1:0][7:0]       pat_bytes,
    output logic [LEN_W-1:0]                  used_len,
    output logic                              bad_pattern
);
    import wsrm_pkg::*;

    logic [PATTERN_MAX-1:0][7:0] pat_reg;
    logic [LEN_REG_W-1:0]        len_reg;
    cfg_idx_t                    wr_idx;

    assign wr_idx = cfg_idx_t'(cfg_wr_index);

    genvar k;
    for (k = 0; k < PATTERN_MAX; k++) begin : g_byte
        if (k < 8) begin : g_low
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    pat_reg[k] <= '0;
                end else if (cfg_wr_en && wr_idx == CFG_PAT_LOW) begin
                    pat_reg[k] <= cfg_wr_data[8*k +: 8];
                end
            end
        end else begin : g_high
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    pat_reg[k] <= '0;
                end else if (cfg_wr_en && wr_idx == CFG_PAT_HIGH) begin
                    pat_reg[k] <= cfg_wr_data[8*(k-8) +: 8];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else if (cfg_wr_en && wr_idx == CFG_PAT_LEN) begin
            len_reg <= cfg_wr_data[LEN_REG_W-1:0];
        end
    end

    // Lengths beyond the pattern storage are clamped to its size.
    always_comb begin
        if (len_reg > LEN_REG_W'(PATTERN_MAX)) begin
            used_len = LEN_W'(PATTERN_MAX);
        end else begin
            used_len = len_reg[LEN_W-1:0];
        end
    end

    assign pat_bytes   = pat_reg;
    assign bad_pattern = (used_len != '0) && (pat_reg[0] == STAR_BYTE);

endmodule

// ===== sv/wsrm_row_update.sv =====
// Row update of the partial-match table for one item of the wildcard star
// regex matcher: the empty-text row for a start, the next row for a byte.
// Depends on wsrm_pkg.
module wsrm_row_update #(
    parameter int PATTERN_MAX = wsrm_pkg::PATTERN_MAX_DEF,
    parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
    input  logic [PATTERN_MAX:0]        old_row,
    input  logic [PATTERN_MAX-1:0][7:0] pat_bytes,
    input  logic [LEN_W-1:0]            used_len,
    input  logic                        bad_pattern,
    input  wsrm_pkg::wsrm_item_t        item,
    output logic [PATTERN_MAX:0]        new_row,
    output wsrm_pkg::wsrm_result_t      result
);
    import wsrm_pkg::*;

    logic [PATTERN_MAX:0] in_use;
    logic [PATTERN_MAX:0] old_m;
    logic [PATTERN_MAX:0] empty_row;
    logic [PATTERN_MAX:0] step_row;

    assign in_use[0]    = 1'b1;
    assign empty_row[0] = 1'b1;
    assign step_row[0]  = 1'b0;
    assign old_m        = old_row & in_use;

    genvar j;
    for (j = 1; j <= PATTERN_MAX; j++) begin : g_col
        logic p_star;
        logic p_hit;

        assign in_use[j] = (LEN_W'(j) <= used_len);
        assign p_star    = (pat_bytes[j-1] == STAR_BYTE);
        assign p_hit     = (pat_bytes[j-1] == item.text_byte) || (pat_bytes[j-1] == DOT_BYTE);

        if (j >= 2) begin : g_pair
            logic q_hit;
            logic star_val;

            assign q_hit = (pat_bytes[j-2] == item.text_byte) ||
                           (pat_bytes[j-2] == DOT_BYTE);
            // A star either drops its pair or, when the byte before it matches,
            // extends a match that already covered the pair.
            assign star_val = q_hit ? (step_row[j-2] | step_row[j-1] | old_m[j])
                                    : step_row[j-2];

            assign empty_row[j] = in_use[j] & p_star & (empty_row[j-1] | empty_row[j-2]);
            assign step_row[j]  = in_use[j] & (p_star ? star_val : (p_hit & old_m[j-1]));
        end else begin : g_first
            assign empty_row[j] = 1'b0;
            assign step_row[j]  = in_use[j] & ~p_star & p_hit & old_m[j-1];
        end
    end

    always_comb begin
        if (bad_pattern) begin
            new_row = '0;
        end else if (item.req_type == REQ_START) begin
            new_row = empty_row;
        end else begin
            new_row = step_row;
        end
        result.whole_match = new_row[used_len];
        result.bad_pattern = bad_pattern;
    end

endmodule

// ===== sv/wildcard_star_regex_matcher_core.sv =====
// Top level of the wildcard star regex matcher: stream ports, input and
// result registers. Depends on wsrm_pkg, wsrm_cfg_regs and wsrm_row_update.

// The block takes one item per clock cycle for as long as the result side
// keeps up, and every item gives exactly one result, held first in the
// input register and then in the result register. The row of partial
// matches is updated as an item moves between those two registers, so an
// item sees the row left by the item just before it. A start item (tuser 0)
// loads the empty-text row; a byte item (tuser 1) consumes the byte in tdata.
// Results report whole_match in m_tdata bit 0 and bad_pattern in bit 1. The
// user must see that pattern registers are written through the cfg port only
// while the block holds no item in flight; the block does not enforce this.
module wildcard_star_regex_matcher_core #(
    parameter int PATTERN_MAX = wsrm_pkg::PATTERN_MAX_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [wsrm_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [wsrm_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] text_byte
    input  logic                            s_tuser,   // [0] req_type
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata    // [0] whole_match, [1] bad_pattern, [7:2] zero
);
    import wsrm_pkg::*;

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    logic [PATTERN_MAX-1:0][7:0] pat_bytes;
    logic [LEN_W-1:0]            used_len;
    logic                        bad_pattern;

    logic                 in_valid_reg;
    logic                 in_valid_next;
    wsrm_item_t           in_item_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    wsrm_result_t         out_result_reg;
    logic [PATTERN_MAX:0] row_reg;
    logic [PATTERN_MAX:0] row_next;
    wsrm_result_t         result;
    logic                 out_free;
    logic                 advance;
    logic                 s_transfer;

    wsrm_cfg_regs #(
        .PATTERN_MAX (PATTERN_MAX),
        .LEN_W       (LEN_W)
    ) u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .pat_bytes    (pat_bytes),
        .used_len     (used_len),
        .bad_pattern  (bad_pattern)
    );

    wsrm_row_update #(
        .PATTERN_MAX (PATTERN_MAX),
        .LEN_W       (LEN_W)
    ) u_row (
        .old_row     (row_reg),
        .pat_bytes   (pat_bytes),
        .used_len    (used_len),
        .bad_pattern (bad_pattern),
        .item        (in_item_reg),
        .new_row     (row_next),
        .result      (result)
    );

    // The result register frees up in the cycle its transfer completes.
    assign out_free   = !out_valid_reg || m_tready;
    assign advance    = in_valid_reg && out_free;
    assign s_tready   = !in_valid_reg || out_free;
    assign s_transfer = s_tvalid && s_tready;

    always_comb begin
        in_valid_next  = s_transfer || (in_valid_reg && !out_free);
        out_valid_next = advance || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            row_reg       <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_transfer) begin
            in_item_reg.req_type  <= s_tuser;
            in_item_reg.text_byte <= s_tdata;
        end
        if (advance) begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_result_reg.bad_pattern, out_result_reg.whole_match};

endmodule

// ===== sv/wsrm_checker.sv =====
// Port-level checker of the wildcard star regex matcher, bound to the top
// level. Depends on wildcard_star_regex_matcher_core_macros.svh.
`include "wildcard_star_regex_matcher_core_macros.svh"

module wsrm_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // A stalled result holds its value until the transfer completes.
    `WSRM_ASSERT_NEXT(a_out_hold, aclk, aresetn,
        m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
        "result changed while stalled")

    // A leading-star pattern never reports a match.
    `WSRM_ASSERT_IMPLIES(a_bad_no_match, aclk, aresetn,
        m_tvalid, !(m_tdata[0] && m_tdata[1]),
        "match reported with bad pattern")

    // The padding bits of a result are zero.
    `WSRM_ASSERT_IMPLIES(a_pad_zero, aclk, aresetn,
        m_tvalid, m_tdata[7:2] == 6'd0,
        "result padding not zero")

    // The input side only stalls when both registers hold data and the result waits.
    `WSRM_ASSERT_IMPLIES(a_stall_cause, aclk, aresetn,
        !s_tready, m_tvalid && !m_tready,
        "input stalled without a blocked result")

endmodule

bind wildcard_star_regex_matcher_core wsrm_checker u_wsrm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
